// ===== hdl/mcm_pkg.sv =====
// Package for the MIDI channel merge block: item types, outcome codes and
// the command and status structs between controller and datapath.
// No dependencies.
package mcm_pkg;

   // Port numbering and message class bounds
   localparam logic [4:0] SYSTEM_PORT = 5'd0;
   localparam logic [7:0] SYS_BASE    = 8'hF0;
   localparam logic [7:0] VOICE_BASE  = 8'h80;

   // Request kinds
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // Outcome codes
   localparam logic [2:0] OC_ACCEPTED  = 3'd0;
   localparam logic [2:0] OC_FILTERED  = 3'd1;
   localparam logic [2:0] OC_FULL      = 3'd2;
   localparam logic [2:0] OC_TOO_LONG  = 3'd3;
   localparam logic [2:0] OC_DELIVERED = 3'd4;
   localparam logic [2:0] OC_EMPTY     = 3'd5;

   typedef struct packed {
      logic        req_type;
      logic [4:0]  port;
      logic [31:0] stamp;
      logic [7:0]  status_byte;
      logic [63:0] payload;
      logic [3:0]  length;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [31:0] out_stamp;
      logic [7:0]  out_status;
      logic [63:0] out_payload;
      logic [3:0]  out_length;
   } rsp_item_type;

   // One stored event
   typedef struct packed {
      logic [31:0] stamp;
      logic [7:0]  status;
      logic [63:0] payload;
      logic [3:0]  length;
   } entry_type;

   // How the current port index moves
   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_REQ,
      CUR_ZERO,
      CUR_NEXT,
      CUR_BEST
   } cur_op_type;

   typedef struct packed {
      logic       load;
      cur_op_type cur_op;
      logic       rd_issue;
      logic       cmp_en;
      logic       best_clr;
      logic       push_en;
      logic       pop_en;
   } cmd_type;

   typedef struct packed {
      logic cur_last;
   } stat_type;

endpackage

// ===== hdl/midi_channel_merge_core.sv =====
// Top level of the MIDI channel merge block: controller plus datapath.
// Depends on mcm_pkg, mcm_control and mcm_datapath.
//
// Merges timestamped MIDI events from PORTS source queues into one stream.
// An item is taken when start is high and busy is low; its single result
// appears on rsp_item for exactly one cycle with rsp_valid high, and the
// receiver cannot stall it. A push keeps busy high in the PUSH state, and its
// result shows in the cycle after that. A pop keeps busy high through SCAN,
// DRAIN, SEL and COMMIT: the queue heads are read one port per cycle through
// the single event memory port, compared against a running minimum, and the
// winning queue is then advanced; its result follows in the next cycle.
// The event memory needs no clearing after reset.
module midi_channel_merge_core #(
   parameter int PORTS       = 17,
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_BYTES   = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mcm_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output mcm_pkg::rsp_item_type rsp_item
);
   import mcm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mcm_control u_control (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_item.req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   mcm_datapath #(
      .PORTS       (PORTS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_BYTES   (MAX_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== hdl/mcm_control.sv =====
// Controller of the MIDI channel merge block: sequences push and pop items.
// Depends on mcm_pkg.
module mcm_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             req_kind,
   input  mcm_pkg::stat_type stat,
   output mcm_pkg::cmd_type cmd,
   output logic             busy
);
   import mcm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_SCAN,
      ST_DRAIN,
      ST_SEL,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      cmd.cur_op = CUR_HOLD;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_kind == REQ_POP) begin
                  cmd.cur_op   = CUR_ZERO;
                  cmd.best_clr = 1'b1;
                  state_in     = ST_SCAN;
               end else begin
                  cmd.cur_op = CUR_REQ;
                  state_in   = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            cmd.push_en = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.rd_issue = 1'b1;
            cmd.cmp_en   = 1'b1;
            if (stat.cur_last) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.cur_op = CUR_NEXT;
            end
         end
         ST_DRAIN: begin
            cmd.cmp_en = 1'b1;
            state_in   = ST_SEL;
         end
         ST_SEL: begin
            cmd.cur_op = CUR_BEST;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.pop_en = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hdl/mcm_datapath.sv =====
// Datapath of the MIDI channel merge block: event memory, per-port queue
// pointers, push checks, head scan with running minimum, result register.
// Depends on mcm_pkg.
module mcm_datapath #(
   parameter int PORTS       = 17,
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_BYTES   = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mcm_pkg::cmd_type      cmd,
   input  mcm_pkg::req_item_type req_item,
   output mcm_pkg::stat_type     stat,
   output logic                  rsp_valid,
   output mcm_pkg::rsp_item_type rsp_item
);
   import mcm_pkg::*;

   localparam int DEPTH = PORTS * QUEUE_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(PORTS);
   localparam int PW    = $clog2(QUEUE_DEPTH);
   localparam int FW    = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] QD_A     = AW'(QUEUE_DEPTH);
   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);
   localparam logic [IW-1:0] CUR_LAST = IW'(PORTS - 1);
   localparam logic [4:0]    PORTS_5  = 5'(PORTS);
   localparam logic [3:0]    MAXB_4   = 4'(MAX_BYTES);

   entry_type    mem [DEPTH];
   entry_type    rd_ff;
   entry_type    best_ff;
   req_item_type req_ff;
   logic [IW-1:0] cur_ff, cand_port_ff, best_port_ff;
   logic          cand_valid_ff, best_valid_ff;
   logic [PW-1:0] head_ff [PORTS];
   logic [PW-1:0] tail_ff [PORTS];
   logic [FW-1:0] fill_ff [PORTS];
   logic          rsp_valid_ff;
   rsp_item_type  rsp_ff;

   logic [PW-1:0] head_cur, tail_cur, ptr_sel;
   logic [FW-1:0] fill_cur;
   logic [AW-1:0] addr;
   logic [2:0]    push_oc;
   logic [7:0]    push_status;
   logic [63:0]   push_payload;
   logic          in_range;
   logic          better;

   assign head_cur = head_ff[cur_ff];
   assign tail_cur = tail_ff[cur_ff];
   assign fill_cur = fill_ff[cur_ff];
   assign ptr_sel  = cmd.push_en ? tail_cur : head_cur;
   assign addr     = AW'(AW'(cur_ff) * QD_A + AW'(ptr_sel));
   assign in_range = (req_item.port < PORTS_5);
   assign stat.cur_last = (cur_ff == CUR_LAST);

   // Check a push item and form the stored status and payload
   always_comb begin
      push_status = req_ff.status_byte;
      if (req_ff.port >= PORTS_5 || req_ff.length == 4'd0) begin
         push_oc = OC_FILTERED;
      end else if (req_ff.length > MAXB_4) begin
         push_oc = OC_TOO_LONG;
      end else if (req_ff.port == SYSTEM_PORT) begin
         push_oc = (req_ff.status_byte < SYS_BASE) ? OC_FILTERED :
                   (fill_cur >= FILL_MAX) ? OC_FULL : OC_ACCEPTED;
      end else begin
         push_status = {req_ff.status_byte[7:4], 4'(req_ff.port - 5'd1)};
         push_oc = (req_ff.status_byte < VOICE_BASE || req_ff.status_byte >= SYS_BASE) ?
                   OC_FILTERED : (fill_cur >= FILL_MAX) ? OC_FULL : OC_ACCEPTED;
      end
   end

   // Drop payload bytes beyond the message length
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         push_payload[i*8 +: 8] = (5'(i + 1) < {1'b0, req_ff.length}) ?
                                  req_ff.payload[i*8 +: 8] : 8'h00;
      end
   end

   assign better = cand_valid_ff && (!best_valid_ff || rd_ff.stamp < best_ff.stamp);

   // Event memory: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.push_en && push_oc == OC_ACCEPTED) begin
         mem[addr] <= '{stamp: req_ff.stamp, status: push_status,
                        payload: push_payload, length: req_ff.length};
      end
      if (cmd.rd_issue) begin
         rd_ff <= mem[addr];
      end
   end

   // Latch the request and track the scan candidate and the best head
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.rd_issue) begin
         cand_port_ff <= cur_ff;
      end
      if (cmd.cmp_en && better) begin
         best_ff      <= rd_ff;
         best_port_ff <= cand_port_ff;
      end
   end

   // Control registers: port index, flags, pointers, result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff        <= '0;
         cand_valid_ff <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int p = 0; p < PORTS; p++) begin
            head_ff[p] <= '0;
            tail_ff[p] <= '0;
            fill_ff[p] <= '0;
         end
      end else begin
         case (cmd.cur_op)
            CUR_HOLD: cur_ff <= cur_ff;
            CUR_REQ:  cur_ff <= in_range ? req_item.port[IW-1:0] : '0;
            CUR_ZERO: cur_ff <= '0;
            CUR_NEXT: cur_ff <= cur_ff + 1'b1;
            CUR_BEST: cur_ff <= best_port_ff;
            default:  cur_ff <= cur_ff;
         endcase
         cand_valid_ff <= cmd.rd_issue && (fill_cur != '0);
         if (cmd.best_clr) begin
            best_valid_ff <= 1'b0;
         end else if (cmd.cmp_en && better) begin
            best_valid_ff <= 1'b1;
         end
         // Advance tail on an accepted push, head on a delivered pop
         if (cmd.push_en && push_oc == OC_ACCEPTED) begin
            tail_ff[cur_ff] <= (tail_cur == PTR_LAST) ? '0 : tail_cur + 1'b1;
            fill_ff[cur_ff] <= fill_cur + 1'b1;
         end
         if (cmd.pop_en && best_valid_ff) begin
            head_ff[cur_ff] <= (head_cur == PTR_LAST) ? '0 : head_cur + 1'b1;
            fill_ff[cur_ff] <= fill_cur - 1'b1;
         end
         rsp_valid_ff <= cmd.push_en || cmd.pop_en;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.push_en) begin
         rsp_ff <= '{outcome: push_oc, out_stamp: '0, out_status: '0,
                     out_payload: '0, out_length: '0};
      end else if (cmd.pop_en) begin
         if (best_valid_ff) begin
            rsp_ff <= '{outcome: OC_DELIVERED, out_stamp: best_ff.stamp,
                        out_status: best_ff.status, out_payload: best_ff.payload,
                        out_length: best_ff.length};
         end else begin
            rsp_ff <= '{outcome: OC_EMPTY, out_stamp: '0, out_status: '0,
                        out_payload: '0, out_length: '0};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== bench/tb_midi_channel_merge_core.sv =====
// Testbench for midi_channel_merge_core: directed and random push/pop items,
// an in-bench merge predictor and a field-by-field check of every result.
// Depends on mcm_pkg and the midi_channel_merge_core RTL.
module tb_midi_channel_merge_core;
   import mcm_pkg::*;

   localparam int PORTS         = 17;
   localparam int QUEUE_DEPTH   = 16;
   localparam int MAX_BYTES     = 9;
   localparam int SETTLE_CYCLES = PORTS + 8;
   localparam int SEGMENTS      = 20;
   localparam int SEGMENT_ITEMS = 60;

   logic         clock;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   logic         rsp_valid;
   req_item_type req_item = '0;
   rsp_item_type rsp_item;

   midi_channel_merge_core #(
      .PORTS(PORTS),
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .MAX_BYTES(MAX_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   // Predictor copy of the per-port event queues
   entry_type    port_events [PORTS][QUEUE_DEPTH];
   int           port_head [PORTS];
   int           port_tail [PORTS];
   int           port_fill [PORTS];

   req_item_type pending_items[$];
   bit           wait_for_drain[$];
   rsp_item_type due_results[$];
   int           errors = 0;
   bit           taken;
   int           gap_left = 0;
   bit           no_idle = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Reset, released at a falling edge
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Predict the result of one item and update the queue copy
   function automatic rsp_item_type predict_merge(req_item_type item);
      rsp_item_type res;
      logic [7:0]   status;
      logic [63:0]  keep;
      int           best;
      int           p;
      res  = '0;
      best = -1;
      if (item.req_type == REQ_PUSH) begin
         status = item.status_byte;
         if (item.port >= PORTS || item.length == 0) begin
            res.outcome = OC_FILTERED;
         end else if (item.length > MAX_BYTES) begin
            res.outcome = OC_TOO_LONG;
         end else if (item.port == SYSTEM_PORT ? status < SYS_BASE
                      : (status < VOICE_BASE || status >= SYS_BASE)) begin
            res.outcome = OC_FILTERED;
         end else if (port_fill[item.port] >= QUEUE_DEPTH) begin
            res.outcome = OC_FULL;
         end else begin
            // rewrite the channel nibble on voice ports
            if (item.port != SYSTEM_PORT) status[3:0] = item.port[3:0] - 4'd1;
            keep = (item.length > 8) ? '1 : (64'd1 << (8 * (item.length - 1))) - 64'd1;
            p = item.port;
            port_events[p][port_tail[p]] = '{stamp: item.stamp, status: status,
                                             payload: item.payload & keep,
                                             length: item.length};
            port_tail[p] = (port_tail[p] + 1) % QUEUE_DEPTH;
            port_fill[p]++;
            res.outcome = OC_ACCEPTED;
         end
      end else begin
         // pick the oldest head; lowest port wins ties
         for (p = 0; p < PORTS; p++) begin
            if (port_fill[p] != 0 &&
                (best < 0 || port_events[p][port_head[p]].stamp
                             < port_events[best][port_head[best]].stamp))
               best = p;
         end
         if (best < 0) begin
            res.outcome = OC_EMPTY;
         end else begin
            res.outcome     = OC_DELIVERED;
            res.out_stamp   = port_events[best][port_head[best]].stamp;
            res.out_status  = port_events[best][port_head[best]].status;
            res.out_payload = port_events[best][port_head[best]].payload;
            res.out_length  = port_events[best][port_head[best]].length;
            port_head[best] = (port_head[best] + 1) % QUEUE_DEPTH;
            port_fill[best]--;
         end
      end
      return res;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Check results, then record the item taken at this edge
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, actual %h", $time, rsp_item);
            end else begin
               want = due_results.pop_front();
               check_field("outcome", 64'(want.outcome), 64'(rsp_item.outcome));
               check_field("out_stamp", 64'(want.out_stamp), 64'(rsp_item.out_stamp));
               check_field("out_status", 64'(want.out_status), 64'(rsp_item.out_status));
               check_field("out_payload", want.out_payload, rsp_item.out_payload);
               check_field("out_length", 64'(want.out_length), 64'(rsp_item.out_length));
            end
         end
         if (start && !busy) due_results.push_back(predict_merge(req_item));
         taken <= start && !busy;
      end
   end

   // Draw the idle gap after an item; flip into and out of gapless stretches
   function automatic int draw_gap();
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      return no_idle ? 0 : $urandom_range(0, 16);
   endfunction

   // Present items from the queue, holding each until it is taken
   always @(negedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
      end else if (!start || taken) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_items.size() != 0 &&
                      !(wait_for_drain[0] && due_results.size() != 0)) begin
            req_item <= pending_items.pop_front();
            void'(wait_for_drain.pop_front());
            start    <= 1'b1;
            gap_left = draw_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic req_item_type push_item(logic [4:0] port, logic [31:0] stamp,
                                              logic [7:0] status, logic [63:0] payload,
                                              logic [3:0] length);
      return '{req_type: REQ_PUSH, port: port, stamp: stamp, status_byte: status,
               payload: payload, length: length};
   endfunction

   // Pop with random content in the ignored fields
   function automatic req_item_type pop_item();
      return '{req_type: REQ_POP, port: 5'($urandom), stamp: $urandom,
               status_byte: 8'($urandom), payload: {$urandom, $urandom},
               length: 4'($urandom)};
   endfunction

   // Random item, mostly well formed for its port
   function automatic req_item_type random_item(int pop_pct, int port_lo, int port_hi);
      req_item_type it;
      int           pick;
      if ($urandom_range(0, 99) < pop_pct) return pop_item();
      it.req_type = REQ_PUSH;
      it.port = ($urandom_range(0, 15) == 0) ? 5'($urandom)
                                             : 5'($urandom_range(port_lo, port_hi));
      pick = $urandom_range(0, 3);
      it.stamp = (pick == 0) ? $urandom :
                 (pick == 1) ? $urandom_range(0, 15) :
                 (pick == 2) ? {28'hFFFFFFF, 4'($urandom)} : $urandom_range(0, 1000);
      it.length = ($urandom_range(0, 11) == 0) ? 4'($urandom)
                                               : 4'($urandom_range(1, MAX_BYTES));
      if ($urandom_range(0, 7) == 0)
         it.status_byte = 8'($urandom);
      else if (it.port == SYSTEM_PORT)
         it.status_byte = 8'($urandom_range(SYS_BASE, 255));
      else
         it.status_byte = 8'($urandom_range(VOICE_BASE, SYS_BASE - 1));
      it.payload = {$urandom, $urandom};
      return it;
   endfunction

   task automatic queue_item(req_item_type item, bit drain_first);
      pending_items.push_back(item);
      wait_for_drain.push_back(drain_first);
   endtask

   // Stimulus and end of run
   initial begin
      int seg;
      int n;
      int mode;
      int lo;
      req_item_type it;

      // pop with nothing pending
      queue_item(pop_item(), 1'b0);
      // system port: extreme stamps, both ends of the class, full and empty payload
      queue_item(push_item(5'd0, 32'hFFFFFFFF, 8'hF0, '1, 4'd9), 1'b0);
      queue_item(push_item(5'd0, 32'h0, 8'hFF, '1, 4'd1), 1'b0);
      queue_item(push_item(5'd0, 32'd3, 8'hEF, '1, 4'd2), 1'b0);
      // voice ports: both ends of the class and the channel rewrite
      queue_item(push_item(5'd1, 32'd5, 8'h80, {$urandom, $urandom}, 4'd3), 1'b0);
      queue_item(push_item(5'd16, 32'd5, 8'hEF, {$urandom, $urandom}, 4'd2), 1'b0);
      queue_item(push_item(5'd1, 32'd5, 8'h7F, '1, 4'd3), 1'b0);
      queue_item(push_item(5'd2, 32'd5, 8'hF8, '1, 4'd3), 1'b0);
      // port out of range, also ahead of the length test
      queue_item(push_item(5'd17, 32'd1, 8'h90, '1, 4'd3), 1'b0);
      queue_item(push_item(5'd31, 32'd1, 8'h90, '1, 4'd15), 1'b0);
      // zero length, then too long ahead of the class filter
      queue_item(push_item(5'd3, 32'd1, 8'h90, '1, 4'd0), 1'b0);
      queue_item(push_item(5'd3, 32'd1, 8'h00, '1, 4'd10), 1'b0);
      queue_item(push_item(5'd3, 32'd1, 8'h90, '1, 4'd15), 1'b0);
      // third head at the tied stamp
      queue_item(push_item(5'd2, 32'd5, 8'h95, '1, 4'd9), 1'b0);
      // drain in merge order, then pop empty again
      repeat (7) queue_item(pop_item(), 1'b0);

      // random segments: broad mix, pushes focused on two ports, drain-heavy
      for (seg = 0; seg < SEGMENTS; seg++) begin
         mode = $urandom_range(0, 2);
         lo   = $urandom_range(0, PORTS - 2);
         for (n = 0; n < SEGMENT_ITEMS; n++) begin
            case (mode)
               0: it = random_item(45, 0, PORTS - 1);
               1: it = random_item(15, lo, lo + 1);
               default: it = random_item(75, 0, PORTS - 1);
            endcase
            queue_item(it, n == 0 && (seg == 0 || $urandom_range(0, 2) == 0));
         end
      end

      // wait for the last item to be taken and every result to arrive
      while (pending_items.size() != 0 || start) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && due_results.size() == 0)
         $display("midi_channel_merge_core test passed");
      else
         $display("midi_channel_merge_core test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #(12 * 500000);
      $display("midi_channel_merge_core test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/mcm_pkg.sv
hdl/mcm_control.sv
hdl/mcm_datapath.sv
hdl/midi_channel_merge_core.sv
bench/tb_midi_channel_merge_core.sv
